// File: rtl/core/cak_pkg.sv
// ---------------------------------------------------------------------------
// cak_pkg: shared definitions for the color-key alpha paste block
// Register indexes, band mode codes, blend constants and the per-pixel
// control group passed from the select stage to the blend stage.
// ---------------------------------------------------------------------------
package cak_pkg;

  // Default field widths.
  localparam int COORD_BITS_DEF   = 12;
  localparam int CHANNEL_BITS_DEF = 8;

  // Number of color channels carried per pixel.
  localparam int NUM_CH = 3;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ALPHA = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_MODE   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_SPAN    = 3'd7;

  // Band modes.
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_GRAY          = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COLOR         = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GRAY_TO_COLOR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COLOR_TO_GRAY = 2'd3;

  // Alpha is a 0..256 weight; the blend divides by 256 with rounding.
  localparam int ALPHA_W     = 9;
  localparam int ALPHA_SHIFT = 8;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;
  localparam logic [ALPHA_W-1:0] ROUND_HALF = 9'd128;

  // Per-pixel decision handed from the select stage to the blend stage.
  typedef struct packed {
    logic              paste;
    logic [NUM_CH-1:0] blend_en;
  } ctl_t;

endpackage

// File: rtl/core/cak_select.sv
// ---------------------------------------------------------------------------
// cak_select: window test, color-key test and source selection
// Decides whether a pixel is pasted, which channels blend, and which source
// value each channel blends toward (including the rounded gray average).
// ---------------------------------------------------------------------------
module cak_select
  import cak_pkg::*;
#(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]                dst_x,
  input  logic [COORD_BITS-1:0]                dst_y,
  input  logic [NUM_CH-1:0][CHANNEL_BITS-1:0]  src,
  input  logic [COORD_BITS:0]                  x_offset,
  input  logic [COORD_BITS:0]                  y_offset,
  input  logic [COORD_BITS:0]                  src_width,
  input  logic [COORD_BITS:0]                  src_height,
  input  logic [MODE_W-1:0]                    band_mode,
  input  logic [NUM_CH*CHANNEL_BITS-1:0]       key_low,
  input  logic [NUM_CH*CHANNEL_BITS-1:0]       key_span,
  output ctl_t                                 ctl,
  output logic [NUM_CH-1:0][CHANNEL_BITS-1:0]  src_sel
);

  localparam int DIFF_W = COORD_BITS + 2;
  // Sum of three channels plus one.
  localparam int SUM_W  = CHANNEL_BITS + 2;
  // Reciprocal of three, exact for every sum below 2**SUM_W.
  localparam int RECIP_SHIFT = SUM_W + 1;
  localparam logic [RECIP_SHIFT-1:0] GRAY_RECIP =
    RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
  localparam int PROD_W = SUM_W + RECIP_SHIFT;

  logic [DIFF_W-1:0]       u;
  logic [DIFF_W-1:0]       v;
  logic                    in_window;
  logic [NUM_CH-1:0]       key_out;
  logic [SUM_W-1:0]        gray_sum;
  logic [PROD_W-1:0]       gray_prod;
  logic [CHANNEL_BITS-1:0] gray;
  logic                    any_out;

  // Window test: offset coordinates must be non-negative and below the size.
  always_comb begin
    u = {2'b00, dst_x} - {x_offset[COORD_BITS], x_offset};
    v = {2'b00, dst_y} - {y_offset[COORD_BITS], y_offset};
    in_window = !u[DIFF_W-1] && !v[DIFF_W-1] &&
                (u[COORD_BITS:0] < src_width) && (v[COORD_BITS:0] < src_height);
  end

  // Key test per channel; the upper bound is one bit wider so it cannot wrap.
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      key_out[k] =
        (src[k] < key_low[k*CHANNEL_BITS +: CHANNEL_BITS]) ||
        ({1'b0, src[k]} > ({1'b0, key_low[k*CHANNEL_BITS +: CHANNEL_BITS]} +
                           {1'b0, key_span[k*CHANNEL_BITS +: CHANNEL_BITS]}));
    end
  end

  // Rounded mean of the three source channels by reciprocal multiply.
  always_comb begin
    gray_sum  = SUM_W'(src[0]) + SUM_W'(src[1]) + SUM_W'(src[2]) + SUM_W'(1);
    gray_prod = PROD_W'(gray_sum) * PROD_W'(GRAY_RECIP);
    gray      = gray_prod[RECIP_SHIFT +: CHANNEL_BITS];
  end

  assign any_out = |key_out;

  // Mode decode: which key channels count, which channels blend, and toward what.
  always_comb begin
    src_sel = src;
    ctl     = '0;
    case (band_mode)
      MODE_GRAY: begin
        ctl.paste    = in_window && key_out[0];
        ctl.blend_en = {{(NUM_CH-1){1'b0}}, ctl.paste};
      end
      MODE_COLOR: begin
        ctl.paste    = in_window && any_out;
        ctl.blend_en = {NUM_CH{ctl.paste}};
      end
      MODE_GRAY_TO_COLOR: begin
        ctl.paste    = in_window && key_out[0];
        ctl.blend_en = {NUM_CH{ctl.paste}};
        src_sel      = {NUM_CH{src[0]}};
      end
      default: begin
        ctl.paste    = in_window && any_out;
        ctl.blend_en = {{(NUM_CH-1){1'b0}}, ctl.paste};
        src_sel[0]   = gray;
      end
    endcase
  end

endmodule

// File: rtl/core/cak_blend.sv
// ---------------------------------------------------------------------------
// cak_blend: one-channel alpha blend
// Computes (d*(256-a) + s*a + 128) >> 8 when enabled, else passes d.
// ---------------------------------------------------------------------------
module cak_blend
  import cak_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic [CHANNEL_BITS-1:0] d,
  input  logic [CHANNEL_BITS-1:0] s,
  input  logic [ALPHA_W-1:0]      alpha,
  input  logic                    en,
  output logic [CHANNEL_BITS-1:0] y
);

  localparam int PROD_W = CHANNEL_BITS + ALPHA_W;

  logic [ALPHA_W-1:0] inv_alpha;
  logic [PROD_W-1:0]  prod_d;
  logic [PROD_W-1:0]  prod_s;
  logic [PROD_W:0]    sum;

  // Weighted sum with rounding, then drop the eight fraction bits.
  always_comb begin
    inv_alpha = ALPHA_ONE - alpha;
    prod_d    = PROD_W'(d) * PROD_W'(inv_alpha);
    prod_s    = PROD_W'(s) * PROD_W'(alpha);
    sum       = (PROD_W+1)'(prod_d) + (PROD_W+1)'(prod_s) + (PROD_W+1)'(ROUND_HALF);
    y         = en ? sum[ALPHA_SHIFT +: CHANNEL_BITS] : d;
  end

endmodule

// File: rtl/core/color_key_alpha_paste_top.sv
// ---------------------------------------------------------------------------
// color_key_alpha_paste_top: color-key compositor with alpha blend
// Usage: each s_axis request carries a destination coordinate, the
// destination pixel and the source pixel aligned to it. One m_axis request
// comes back per input: the composited pixel in tdata and a pasted flag in
// tuser. Pixels inside the configured source window whose source color lies
// outside the key range are blended toward the source by blend_alpha.
// An accepted pixel is held in the select register and then in the output
// register. A select stage (window, key, gray mean) and a blend stage (one
// multiply pair per channel) feed the output register. Throughput is one
// pixel per clock while the receiver does not stall.
// When the receiver stalls, the output register holds its request; the
// select stage still takes one more pixel, then s_axis_tready drops.
// Configuration goes through the cfg channel (always ready) and is meant to
// be written only while no pixel is in flight.
// Reset (rst, synchronous) empties both stages and loads register defaults:
// zero offsets, a 1x1 window, full alpha, gray mode and a zero key.
// ---------------------------------------------------------------------------
module color_key_alpha_paste_top
  import cak_pkg::*;
#(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int IN_W        = 2*COORD_BITS + 2*NUM_CH*CHANNEL_BITS,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((NUM_CH*CHANNEL_BITS + 7) / 8) * 8,
  localparam int KEY_W       = NUM_CH*CHANNEL_BITS,
  localparam int CFG_W       = (KEY_W > COORD_BITS + 1) ? KEY_W : COORD_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  // Fields from bit 0: dst_x, dst_y, dst_c0, dst_c1, dst_c2, src_c0, src_c1, src_c2.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tdata fields from bit 0: out_c0, out_c1, out_c2; tuser: pasted.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int REG_W = COORD_BITS + 1;

  // Configuration registers.
  logic [REG_W-1:0]   x_offset;
  logic [REG_W-1:0]   y_offset;
  logic [REG_W-1:0]   src_width;
  logic [REG_W-1:0]   src_height;
  logic [ALPHA_W-1:0] alpha;
  logic [MODE_W-1:0]  band_mode;
  logic [KEY_W-1:0]   key_low;
  logic [KEY_W-1:0]   key_span;

  // Input unpacking.
  logic [COORD_BITS-1:0]               dst_x;
  logic [COORD_BITS-1:0]               dst_y;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] dst_in;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] src_in;

  // Select stage outputs and registers.
  ctl_t                                ctl_sel;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] src_sel;
  logic                                v1;
  ctl_t                                ctl1;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] d1;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] s1;

  // Blend results and output register.
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] blended;
  logic                                out_v;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] out_data;
  logic                                out_pasted;
  logic                                out_ready;
  logic [ALPHA_W-1:0]                  alpha_in;

  assign cfg_ready = 1'b1;
  assign alpha_in  = cfg_data[ALPHA_W-1:0];

  // Register writes; alpha saturates at one.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset   <= '0;
      y_offset   <= '0;
      src_width  <= REG_W'(1);
      src_height <= REG_W'(1);
      alpha      <= ALPHA_ONE;
      band_mode  <= MODE_GRAY;
      key_low    <= '0;
      key_span   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_OFFSET:    x_offset   <= cfg_data[REG_W-1:0];
        REG_Y_OFFSET:    y_offset   <= cfg_data[REG_W-1:0];
        REG_SRC_WIDTH:   src_width  <= cfg_data[REG_W-1:0];
        REG_SRC_HEIGHT:  src_height <= cfg_data[REG_W-1:0];
        REG_BLEND_ALPHA: alpha      <= (alpha_in > ALPHA_ONE) ? ALPHA_ONE : alpha_in;
        REG_BAND_MODE:   band_mode  <= cfg_data[MODE_W-1:0];
        REG_KEY_LOW:     key_low    <= cfg_data[KEY_W-1:0];
        REG_KEY_SPAN:    key_span   <= cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Field extraction from the input bus.
  always_comb begin
    dst_x = s_axis_tdata[COORD_BITS-1:0];
    dst_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    for (int k = 0; k < NUM_CH; k++) begin
      dst_in[k] = s_axis_tdata[2*COORD_BITS + k*CHANNEL_BITS +: CHANNEL_BITS];
      src_in[k] = s_axis_tdata[2*COORD_BITS + (NUM_CH+k)*CHANNEL_BITS +: CHANNEL_BITS];
    end
  end

  cak_select #(
    .COORD_BITS   (COORD_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_select (
    .dst_x      (dst_x),
    .dst_y      (dst_y),
    .src        (src_in),
    .x_offset   (x_offset),
    .y_offset   (y_offset),
    .src_width  (src_width),
    .src_height (src_height),
    .band_mode  (band_mode),
    .key_low    (key_low),
    .key_span   (key_span),
    .ctl        (ctl_sel),
    .src_sel    (src_sel)
  );

  // Each stage moves when the one after it is empty or moving.
  assign out_ready     = !out_v || m_axis_tready;
  assign s_axis_tready = !v1 || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        v1 <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_v <= v1;
      end
    end
  end

  // Select stage payload.
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ctl1 <= ctl_sel;
      d1   <= dst_in;
      s1   <= src_sel;
    end
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_blend
    cak_blend #(
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_blend (
      .d     (d1[k]),
      .s     (s1[k]),
      .alpha (alpha),
      .en    (ctl1.blend_en[k]),
      .y     (blended[k])
    );
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_ready && v1) begin
      out_data   <= blended;
      out_pasted <= ctl1.paste;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);
  assign m_axis_tuser  = out_pasted;

`ifndef NO_ASSERTIONS
  // No channel blends unless the pixel is pasted.
  a_blend_needs_paste: assert property (@(posedge clk) disable iff (rst)
    (v1 && !ctl1.paste) |-> (ctl1.blend_en == '0))
    else $error("blend enabled on a pixel that is not pasted");

  // Gray destination modes leave channels one and two untouched.
  a_gray_dst_passes: assert property (@(posedge clk) disable iff (rst)
    (v1 && (band_mode == MODE_GRAY || band_mode == MODE_COLOR_TO_GRAY))
      |-> (ctl1.blend_en[NUM_CH-1:1] == '0))
    else $error("upper channels blended in a gray destination mode");

  // A pixel that is not pasted reaches the output as the destination pixel.
  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    (out_ready && v1 && !ctl1.paste) |=> (out_data == $past(d1) && !out_pasted))
    else $error("unpasted pixel altered on its way to the output");

  // Saturation keeps alpha within one.
  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    alpha <= ALPHA_ONE)
    else $error("alpha register above one");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

// File: tb/tb_color_key_alpha_paste_top.sv
// ---------------------------------------------------------------------------
// tb_color_key_alpha_paste_top: self-checking bench for the color-key paster
// Streams pixels into the compositor under several register settings and
// compares every output request with a local model of the window test, the
// key test, the four band modes and the rounded alpha blend. Both stream
// sides idle at random, and one phase holds the output off for a long time.
// ---------------------------------------------------------------------------
module tb_color_key_alpha_paste_top;
  import cak_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_W       = 24;
  localparam int CYCLE_LIMIT = 400000;

  // Input request, packed so that dst_x lands in the lowest bits of tdata.
  typedef struct packed {
    logic [7:0]  src_c2;
    logic [7:0]  src_c1;
    logic [7:0]  src_c0;
    logic [7:0]  dst_c2;
    logic [7:0]  dst_c1;
    logic [7:0]  dst_c0;
    logic [11:0] dst_y;
    logic [11:0] dst_x;
  } pixel_t;

  // Output request as {tuser, tdata}.
  typedef struct packed {
    logic       pasted;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } comp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Local copy of the register file, starting at the reset values.
  logic signed [12:0] win_x0 = '0;
  logic signed [12:0] win_y0 = '0;
  logic [12:0]        win_w = 13'd1;
  logic [12:0]        win_h = 13'd1;
  logic [8:0]         alpha_w = ALPHA_ONE;
  logic [1:0]         mode_r = MODE_GRAY;
  logic [23:0]        key_lo = '0;
  logic [23:0]        key_span = '0;

  comp_t expected_px[$];
  int    err_count = 0;
  int    tx_idle_pct = 15;
  int    rx_idle_pct = 56;
  int    hold_left = 0;
  int    cycle_count = 0;

  color_key_alpha_paste_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A channel is transparent when its source value lies in [lo, lo + span].
  function automatic logic off_key(input logic [7:0] s, input int k);
    int lo;
    int hi;
    lo = int'(key_lo[k*8 +: 8]);
    hi = lo + int'(key_span[k*8 +: 8]);
    return int'(s) < lo || int'(s) > hi;
  endfunction

  // Rounded blend of destination toward source by the current alpha.
  function automatic logic [7:0] mix(input logic [7:0] d, input logic [7:0] s);
    int t;
    t = int'(d) * (256 - int'(alpha_w)) + int'(s) * int'(alpha_w) + 128;
    return 8'(t >> 8);
  endfunction

  // Expected output for one pixel under the current registers.
  function automatic comp_t composite(input pixel_t p);
    int    u;
    int    v;
    int    g;
    logic  paste;
    comp_t r;
    u = int'(p.dst_x) - int'(win_x0);
    v = int'(p.dst_y) - int'(win_y0);
    paste = 1'b0;
    if (u >= 0 && v >= 0 && u < int'(win_w) && v < int'(win_h)) begin
      if (mode_r == MODE_GRAY || mode_r == MODE_GRAY_TO_COLOR) begin
        paste = off_key(p.src_c0, 0);
      end else begin
        paste = off_key(p.src_c0, 0) || off_key(p.src_c1, 1) || off_key(p.src_c2, 2);
      end
    end
    r.pasted = paste;
    r.c0 = p.dst_c0;
    r.c1 = p.dst_c1;
    r.c2 = p.dst_c2;
    if (paste) begin
      case (mode_r)
        MODE_GRAY: begin
          r.c0 = mix(p.dst_c0, p.src_c0);
        end
        MODE_COLOR: begin
          r.c0 = mix(p.dst_c0, p.src_c0);
          r.c1 = mix(p.dst_c1, p.src_c1);
          r.c2 = mix(p.dst_c2, p.src_c2);
        end
        MODE_GRAY_TO_COLOR: begin
          r.c0 = mix(p.dst_c0, p.src_c0);
          r.c1 = mix(p.dst_c1, p.src_c0);
          r.c2 = mix(p.dst_c2, p.src_c0);
        end
        default: begin
          // Nearest integer to the mean of the three source channels.
          g = (int'(p.src_c0) + int'(p.src_c1) + int'(p.src_c2) + 1) / 3;
          r.c0 = mix(p.dst_c0, 8'(g));
        end
      endcase
    end
    return r;
  endfunction

  function automatic pixel_t mk_pixel(input int x, input int y, input int d0, input int d1,
                                      input int d2, input int s0, input int s1, input int s2);
    pixel_t p;
    p.dst_x  = 12'(x);
    p.dst_y  = 12'(y);
    p.dst_c0 = 8'(d0);
    p.dst_c1 = 8'(d1);
    p.dst_c2 = 8'(d2);
    p.src_c0 = 8'(s0);
    p.src_c1 = 8'(s1);
    p.src_c2 = 8'(s2);
    return p;
  endfunction

  // Register value with random junk above its width now and then.
  function automatic logic [23:0] with_junk(input int v, input int width);
    logic [23:0] mask;
    mask = (24'd1 << width) - 24'd1;
    if ($urandom_range(0, 3) == 0) begin
      return (24'($urandom) & ~mask) | (24'(v) & mask);
    end
    return 24'(v) & mask;
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 7))
      0: return -4096;
      1: return 4095;
      2: return -int'($urandom_range(1, 40));
      default: return int'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4096;
      2: return 8191;
      3: return 1;
      default: return int'($urandom_range(2, 48));
    endcase
  endfunction

  // Pick a coordinate near either edge of the window, just outside included.
  function automatic logic [11:0] near_window(input int base, input int size);
    int span;
    int start;
    span = (size > 40) ? 40 : size;
    start = ($urandom_range(0, 1) == 1) ? base : base + size - span;
    return 12'(start + int'($urandom_range(0, span + 1)) - 1);
  endfunction

  // Random pixel, mostly aimed at the window and at the key boundaries.
  function automatic pixel_t random_pixel();
    pixel_t     p;
    logic [7:0] s [3];
    int         lo;
    int         hi;
    p = pixel_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(0, 4) != 0) begin
      p.dst_x = near_window(int'(win_x0), int'(win_w));
      p.dst_y = near_window(int'(win_y0), int'(win_h));
    end
    s[0] = p.src_c0;
    s[1] = p.src_c1;
    s[2] = p.src_c2;
    for (int k = 0; k < 3; k++) begin
      lo = int'(key_lo[k*8 +: 8]);
      hi = lo + int'(key_span[k*8 +: 8]);
      case ($urandom_range(0, 4))
        0: s[k] = 8'(lo - 1);
        1: s[k] = 8'(hi + 1);
        2, 3: s[k] = 8'((hi > 255) ? int'($urandom_range(lo, 255)) : int'($urandom_range(lo, hi)));
        default: ;
      endcase
    end
    p.src_c0 = s[0];
    p.src_c1 = s[1];
    p.src_c2 = s[2];
    return p;
  endfunction

  // Offer one pixel, with a random gap first, and record its expected result.
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk); while (!s_axis_tready);
    expected_px.push_back(composite(p));
  endtask

  // Stop offering pixels and let every outstanding result come back.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write; valid stays high for a following write.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_X_OFFSET:    win_x0 = val[12:0];
      REG_Y_OFFSET:    win_y0 = val[12:0];
      REG_SRC_WIDTH:   win_w = val[12:0];
      REG_SRC_HEIGHT:  win_h = val[12:0];
      REG_BLEND_ALPHA: alpha_w = (val[8:0] > ALPHA_ONE) ? ALPHA_ONE : val[8:0];
      REG_BAND_MODE:   mode_r = val[1:0];
      REG_KEY_LOW:     key_lo = val;
      REG_KEY_SPAN:    key_span = val;
      default: ;
    endcase
  endtask

  // Rewrite the whole register file once the pipeline is empty.
  task automatic set_config(input logic [23:0] xo, input logic [23:0] yo, input logic [23:0] w,
                            input logic [23:0] h, input logic [23:0] a, input logic [23:0] mode,
                            input logic [23:0] kl, input logic [23:0] ks);
    wait_drain();
    cfg_write(REG_X_OFFSET, xo);
    cfg_write(REG_Y_OFFSET, yo);
    cfg_write(REG_SRC_WIDTH, w);
    cfg_write(REG_SRC_HEIGHT, h);
    cfg_write(REG_BLEND_ALPHA, a);
    cfg_write(REG_BAND_MODE, mode);
    cfg_write(REG_KEY_LOW, kl);
    cfg_write(REG_KEY_SPAN, ks);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setup();
    int          a;
    logic [23:0] kl;
    logic [23:0] ks;
    case ($urandom_range(0, 9))
      0: a = 0;
      1: a = 256;
      2: a = int'($urandom_range(257, 511));
      default: a = int'($urandom_range(1, 255));
    endcase
    kl = 24'($urandom);
    case ($urandom_range(0, 5))
      0: kl = 24'h000000;
      1: kl = 24'hFFFFFF;
      default: ;
    endcase
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0: ks[k*8 +: 8] = 8'd0;
        1: ks[k*8 +: 8] = 8'd255;
        default: ks[k*8 +: 8] = 8'($urandom_range(0, 60));
      endcase
    end
    set_config(with_junk(pick_offset(), 13), with_junk(pick_offset(), 13),
               with_junk(pick_size(), 13), with_junk(pick_size(), 13), with_junk(a, 9),
               with_junk(int'($urandom_range(0, 3)), 2), kl, ks);
  endtask

  // Reset values: 1x1 window at the origin, full alpha, gray mode, key of zero.
  task automatic test_reset_defaults();
    send_pixel(mk_pixel(0, 0, 200, 17, 99, 0, 255, 255));
    send_pixel(mk_pixel(0, 0, 200, 17, 99, 1, 0, 0));
    send_pixel(mk_pixel(1, 0, 200, 17, 99, 77, 0, 0));
    send_pixel(mk_pixel(0, 1, 200, 17, 99, 77, 0, 0));
  endtask

  // Key bounds are inclusive on both ends, and lo + span does not wrap.
  task automatic test_key_bounds();
    set_config(24'd0, 24'd0, 24'd4096, 24'd4096, 24'd128, 24'(MODE_GRAY),
               24'h101010, 24'h101010);
    send_pixel(mk_pixel(0, 0, 0, 1, 2, 15, 0, 0));
    send_pixel(mk_pixel(5, 9, 255, 1, 2, 16, 0, 0));
    send_pixel(mk_pixel(9, 5, 255, 1, 2, 32, 0, 0));
    send_pixel(mk_pixel(4095, 4095, 255, 255, 255, 33, 255, 255));
    set_config(24'd0, 24'd0, 24'd4096, 24'd4096, 24'd200, 24'(MODE_GRAY),
               24'hFFFFFF, 24'hFFFFFF);
    send_pixel(mk_pixel(3, 3, 10, 20, 30, 254, 0, 0));
    send_pixel(mk_pixel(3, 3, 10, 20, 30, 255, 0, 0));
  endtask

  // Alpha of zero keeps the destination; writes above 256 saturate.
  task automatic test_alpha_extremes();
    set_config(24'd0, 24'd0, 24'd4096, 24'd4096, 24'd0, 24'(MODE_GRAY_TO_COLOR),
               24'd0, 24'd0);
    send_pixel(mk_pixel(1, 1, 0, 128, 255, 255, 0, 0));
    set_config(24'd0, 24'd0, 24'd4096, 24'd4096, 24'h1FF, 24'(MODE_GRAY_TO_COLOR),
               24'd0, 24'd0);
    send_pixel(mk_pixel(2, 2, 255, 0, 3, 9, 0, 0));
    set_config(24'd0, 24'd0, 24'd4096, 24'd4096, 24'hABC101, 24'(MODE_GRAY_TO_COLOR),
               24'd0, 24'd0);
    send_pixel(mk_pixel(2, 2, 0, 255, 3, 255, 0, 0));
    set_config(24'd0, 24'd0, 24'd4096, 24'd4096, 24'd1, 24'(MODE_GRAY_TO_COLOR),
               24'd0, 24'd0);
    send_pixel(mk_pixel(2, 2, 255, 0, 128, 0, 0, 0));
  endtask

  // Color modes paste when any channel leaves its key; gray average rounds.
  task automatic test_band_modes();
    set_config(24'd0, 24'd0, 24'd4096, 24'd4096, 24'd100, 24'(MODE_COLOR),
               24'h0A141E, 24'h050505);
    send_pixel(mk_pixel(7, 7, 90, 91, 92, 30, 20, 10));
    send_pixel(mk_pixel(7, 7, 90, 91, 92, 35, 25, 16));
    set_config(24'd0, 24'd0, 24'd4096, 24'd4096, 24'd100, 24'(MODE_COLOR_TO_GRAY),
               24'h0A141E, 24'h050505);
    send_pixel(mk_pixel(7, 7, 90, 91, 92, 33, 22, 12));
    send_pixel(mk_pixel(7, 7, 90, 91, 92, 1, 1, 2));
    send_pixel(mk_pixel(7, 7, 0, 91, 92, 255, 255, 255));
  endtask

  // Window edges, a negative origin and an empty window.
  task automatic test_window_edges();
    set_config(24'd100, 24'h001000, 24'd10, 24'd8191, 24'd256, 24'(MODE_GRAY),
               24'd0, 24'd0);
    send_pixel(mk_pixel(99, 0, 50, 0, 0, 9, 0, 0));
    send_pixel(mk_pixel(100, 0, 50, 0, 0, 9, 0, 0));
    send_pixel(mk_pixel(109, 4094, 50, 0, 0, 9, 0, 0));
    send_pixel(mk_pixel(110, 0, 50, 0, 0, 9, 0, 0));
    set_config(24'd4095, 24'd0, 24'd1, 24'd0, 24'd256, 24'(MODE_GRAY), 24'd0, 24'd0);
    send_pixel(mk_pixel(4095, 0, 50, 0, 0, 9, 0, 0));
    set_config(24'd4095, 24'd0, 24'd1, 24'd1, 24'd256, 24'(MODE_GRAY), 24'd0, 24'd0);
    send_pixel(mk_pixel(4095, 0, 50, 0, 0, 9, 0, 0));
  endtask

  // Long output stall while the input keeps offering: the block must fill up.
  task automatic test_output_stall();
    set_config(24'd0, 24'd0, 24'd64, 24'd64, 24'd77, 24'(MODE_COLOR), 24'h404040, 24'h202020);
    tx_idle_pct = 0;
    hold_left <= 300;
    repeat (48) send_pixel(random_pixel());
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int per_phase);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (6) begin
      random_setup();
      repeat (per_phase) send_pixel(random_pixel());
    end
  endtask

  // Output side: check each accepted request, then choose the next ready.
  always @(posedge clk) begin
    comp_t got;
    comp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (expected_px.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("unexpected result at %0t: c0=%0d c1=%0d c2=%0d pasted=%0b",
                   $realtime, got.c0, got.c1, got.c2, got.pasted);
        end
      end else begin
        want = expected_px.pop_front();
        if (got.c0 !== want.c0 || got.c1 !== want.c1 || got.c2 !== want.c2 ||
            got.pasted !== want.pasted) begin
          err_count++;
          if (err_count <= 10) begin
            $display("bad result at %0t: expected c0=%0d c1=%0d c2=%0d pasted=%0b, got c0=%0d c1=%0d c2=%0d pasted=%0b",
                     $realtime, want.c0, want.c1, want.c2, want.pasted,
                     got.c0, got.c1, got.c2, got.pasted);
          end
        end
      end
    end
    m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Counts down a requested output hold-off.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("color_key_alpha_paste_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_key_bounds();
    test_alpha_extremes();
    test_band_modes();
    test_window_edges();
    test_output_stall();
    test_random_traffic(15, 56, 104);
    test_random_traffic(56, 15, 104);
    test_random_traffic(0, 0, 104);
    wait_drain();
    repeat (8) @(posedge clk);
    if (err_count == 0 && expected_px.size() == 0) begin
      $display("color_key_alpha_paste_top: match");
    end else begin
      $display("color_key_alpha_paste_top: mismatch");
    end
    $finish;
  end

endmodule
